// File: rtl/lcs_pkg.sv
package lcs_pkg;

  localparam int DEF_MAX_LEN     = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic FUNC_FIRST   = 1'b0;
  localparam logic KIND_LENGTH  = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FEED,
    ST_DRAIN,
    ST_OUT_WAIT,
    ST_TB_READ,
    ST_TB_DEC
  } state_t;

endpackage

// File: rtl/lcs_cell.sv
module lcs_cell #(
  parameter int IDX     = 0,
  parameter int MAX_LEN = lcs_pkg::DEF_MAX_LEN,
  parameter int VW      = lcs_pkg::DEF_VALUE_WIDTH,
  parameter int LW      = 6,
  parameter int IW      = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_en,
  input  logic [VW-1:0] load_value,
  input  logic          clr,
  input  logic [LW-1:0] seq2_len,
  input  logic          in_v,
  input  logic [IW-1:0] in_row,
  input  logic [VW-1:0] in_a,
  input  logic [LW-1:0] in_val,
  input  logic [LW-1:0] in_diag,
  output logic          out_v,
  output logic [IW-1:0] out_row,
  output logic [VW-1:0] out_a,
  output logic [LW-1:0] out_val,
  output logic [LW-1:0] out_diag,
  input  logic [IW-1:0] rd_row,
  output logic          eq_o,
  output logic          dir_o
);

  logic [VW-1:0] b_r;
  logic [LW-1:0] up_r;
  logic          out_v_r;
  logic [IW-1:0] out_row_r;
  logic [VW-1:0] out_a_r;
  logic [LW-1:0] out_val_r;
  logic [LW-1:0] out_diag_r;
  logic          eq_r;
  logic          dir_r;
  logic          eq_mem  [MAX_LEN];
  logic          dir_mem [MAX_LEN];
  logic          border;
  logic          match;
  logic          dir_bit;
  logic [LW-1:0] cur_nxt;

  assign border  = (LW'(IDX) >= seq2_len);
  assign match   = (in_a == b_r);
  assign dir_bit = (up_r >= in_val);

  always_comb begin
    if (border) begin
      cur_nxt = '0;
    end else if (match) begin
      cur_nxt = in_diag + LW'(1);
    end else begin
      cur_nxt = dir_bit ? up_r : in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      b_r <= load_value;
    end
    if (clr) begin
      up_r <= '0;
    end else if (in_v) begin
      up_r <= cur_nxt;
    end
    if (in_v) begin
      out_row_r       <= in_row;
      out_a_r         <= in_a;
      out_val_r       <= cur_nxt;
      out_diag_r      <= up_r;
      eq_mem[in_row]  <= match;
      dir_mem[in_row] <= dir_bit;
    end
    eq_r  <= eq_mem[rd_row];
    dir_r <= dir_mem[rd_row];
  end

  assign out_v    = out_v_r;
  assign out_row  = out_row_r;
  assign out_a    = out_a_r;
  assign out_val  = out_val_r;
  assign out_diag = out_diag_r;
  assign eq_o     = eq_r;
  assign dir_o    = dir_r;

endmodule

// File: rtl/longest_common_subsequence_core.sv
// Longest common subsequence engine.
// Input channel (in_valid/in_ready): one element per transaction; in_func selects
// the first (0) or second (1) sequence and in_last marks the end of a sequence.
// Elements beyond MAX_LEN per sequence are dropped. The last element of the second
// sequence starts the computation.
// A row of MAX_LEN cells, one per element of the second sequence, fills the
// suffix table as a skewed wavefront; the length transaction is offered once
// row 0, the first element of the first sequence, leaves cell 0.
// Output channel (out_valid/out_ready): first a length transaction (out_kind 0),
// then one transaction per subsequence element (out_kind 1); out_end_of_run
// marks the final one. Each traceback step passes through ST_TB_READ and ST_TB_DEC,
// for the registered reads of the first sequence store and of the cell flags;
// there are at most n + m - 1 steps for sequence lengths n and m.
// While results are produced no input is taken; a stalled receiver simply
// holds the output register. Reset clears both lengths and the controller.
module longest_common_subsequence_core #(
  parameter int MAX_LEN     = lcs_pkg::DEF_MAX_LEN,
  parameter int VALUE_WIDTH = lcs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_kind,
  output logic [VALUE_WIDTH-1:0] out_result_value,
  output logic                   out_end_of_run
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  lcs_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] n_r, n_nxt, m_r, m_nxt;
  logic [LW-1:0] feed_r, feed_nxt;
  logic [IW-1:0] ti_r, ti_nxt, tj_r, tj_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [VALUE_WIDTH-1:0] out_val_r, out_val_nxt;
  logic          out_end_r, out_end_nxt;
  logic          inj_v_r;
  logic [IW-1:0] inj_row_r;
  logic [IW-1:0] rd_addr;
  logic [VALUE_WIDTH-1:0] rd_r;
  logic [VALUE_WIDTH-1:0] seq_a_mem [MAX_LEN];
  logic [LW-1:0] feed_row;
  logic          accept_in;
  logic          clr;
  logic          wr_a;

  logic          lv   [MAX_LEN+1];
  logic [IW-1:0] lrow [MAX_LEN+1];
  logic [VALUE_WIDTH-1:0] la [MAX_LEN+1];
  logic [LW-1:0] lval  [MAX_LEN+1];
  logic [LW-1:0] ldiag [MAX_LEN+1];
  logic [MAX_LEN-1:0] cell_eq, cell_dir;

  assign accept_in = in_valid && in_ready;
  assign in_ready  = (state_r == lcs_pkg::ST_LOAD);
  assign feed_row  = n_r - LW'(1) - feed_r;
  assign rd_addr   = (state_r == lcs_pkg::ST_FEED) ? feed_row[IW-1:0] : ti_r;
  assign wr_a      = accept_in && (in_func == lcs_pkg::FUNC_FIRST) && (n_r < LW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      seq_a_mem[n_r[IW-1:0]] <= in_value;
    end
    rd_r      <= seq_a_mem[rd_addr];
    inj_row_r <= feed_row[IW-1:0];
  end

  assign lv[MAX_LEN]    = inj_v_r;
  assign lrow[MAX_LEN]  = inj_row_r;
  assign la[MAX_LEN]    = rd_r;
  assign lval[MAX_LEN]  = '0;
  assign ldiag[MAX_LEN] = '0;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lcs_cell #(
      .IDX(k), .MAX_LEN(MAX_LEN), .VW(VALUE_WIDTH), .LW(LW), .IW(IW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_en   (accept_in && (in_func != lcs_pkg::FUNC_FIRST) && (m_r == LW'(k))),
      .load_value(in_value),
      .clr       (clr),
      .seq2_len  (m_r),
      .in_v      (lv[k+1]),
      .in_row    (lrow[k+1]),
      .in_a      (la[k+1]),
      .in_val    (lval[k+1]),
      .in_diag   (ldiag[k+1]),
      .out_v     (lv[k]),
      .out_row   (lrow[k]),
      .out_a     (la[k]),
      .out_val   (lval[k]),
      .out_diag  (ldiag[k]),
      .rd_row    (ti_r),
      .eq_o      (cell_eq[k]),
      .dir_o     (cell_dir[k])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    feed_nxt      = feed_r;
    ti_nxt        = ti_r;
    tj_nxt        = tj_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    out_end_nxt   = out_end_r;
    clr           = 1'b0;
    unique case (state_r)
      lcs_pkg::ST_LOAD: begin
        if (accept_in) begin
          if (in_func == lcs_pkg::FUNC_FIRST) begin
            if (n_r < LW'(MAX_LEN)) begin
              n_nxt = n_r + LW'(1);
            end
          end else begin
            if (m_r < LW'(MAX_LEN)) begin
              m_nxt = m_r + LW'(1);
            end
            if (in_last) begin
              clr      = 1'b1;
              feed_nxt = '0;
              if (n_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = lcs_pkg::KIND_LENGTH;
                out_val_nxt   = '0;
                out_end_nxt   = 1'b1;
                state_nxt     = lcs_pkg::ST_OUT_WAIT;
              end else begin
                state_nxt = lcs_pkg::ST_FEED;
              end
            end
          end
        end
      end
      lcs_pkg::ST_FEED: begin
        feed_nxt = feed_r + LW'(1);
        if (feed_r == n_r - LW'(1)) begin
          state_nxt = lcs_pkg::ST_DRAIN;
        end
      end
      lcs_pkg::ST_DRAIN: begin
        if (lv[0] && (lrow[0] == '0)) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lcs_pkg::KIND_LENGTH;
          out_val_nxt   = VALUE_WIDTH'(lval[0]);
          out_end_nxt   = (lval[0] == '0);
          rem_nxt       = lval[0];
          ti_nxt        = '0;
          tj_nxt        = '0;
          state_nxt     = lcs_pkg::ST_OUT_WAIT;
        end
      end
      lcs_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_end_r) begin
            n_nxt     = '0;
            m_nxt     = '0;
            state_nxt = lcs_pkg::ST_LOAD;
          end else begin
            state_nxt = lcs_pkg::ST_TB_READ;
          end
        end
      end
      lcs_pkg::ST_TB_READ: begin
        state_nxt = lcs_pkg::ST_TB_DEC;
      end
      lcs_pkg::ST_TB_DEC: begin
        if (cell_eq[tj_r]) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lcs_pkg::KIND_ELEMENT;
          out_val_nxt   = rd_r;
          out_end_nxt   = (rem_r == LW'(1));
          rem_nxt       = rem_r - LW'(1);
          ti_nxt        = ti_r + IW'(1);
          tj_nxt        = tj_r + IW'(1);
          state_nxt     = lcs_pkg::ST_OUT_WAIT;
        end else begin
          if (cell_dir[tj_r]) begin
            ti_nxt = ti_r + IW'(1);
          end else begin
            tj_nxt = tj_r + IW'(1);
          end
          state_nxt = lcs_pkg::ST_TB_READ;
        end
      end
      default: begin
        state_nxt = lcs_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcs_pkg::ST_LOAD;
      n_r         <= '0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
      inj_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
      inj_v_r     <= (state_r == lcs_pkg::ST_FEED);
    end
  end

  always_ff @(posedge clk) begin
    feed_r     <= feed_nxt;
    ti_r       <= ti_nxt;
    tj_r       <= tj_nxt;
    rem_r      <= rem_nxt;
    out_kind_r <= out_kind_nxt;
    out_val_r  <= out_val_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_result_value = out_val_r;
  assign out_end_of_run   = out_end_r;

endmodule

// File: rtl/lcs_checker.sv
module lcs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_end_of_run
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before it was taken.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Input taken while a result is pending.");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_end_of_run |=> !out_valid && in_ready)
    else $error("Block did not return to loading after a run.");

endmodule

bind longest_common_subsequence_core lcs_checker u_lcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_end_of_run(out_end_of_run)
);

// File: tb/longest_common_subsequence_core_test.sv
module longest_common_subsequence_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAX_LEN     = lcs_pkg::DEF_MAX_LEN;
  localparam int  VW          = lcs_pkg::DEF_VALUE_WIDTH;
  localparam logic FUNC_SECOND = ~lcs_pkg::FUNC_FIRST;

  typedef struct {
    logic          kind;
    logic [VW-1:0] value;
    logic          eor;
  } lcs_result_t;

  typedef struct {
    logic          func;
    logic [VW-1:0] value;
    logic          last;
    bit            has_len;
    int            len;
  } elem_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_func = 1'b0;
  logic [VW-1:0] in_value = '0;
  logic          in_last = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_kind;
  logic [VW-1:0] out_result_value;
  logic          out_end_of_run;

  lcs_result_t   pending_results[$];
  logic [VW-1:0] seq_a[MAX_LEN];
  logic [VW-1:0] seq_b[MAX_LEN];
  int            len_a = 0;
  int            len_b = 0;
  int            suffix_lcs[MAX_LEN+1][MAX_LEN+1];

  int  errors = 0;
  int  elems_sent = 0;
  int  runs_done = 0;
  int  results_seen = 0;
  int  dropped = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  longest_common_subsequence_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_result_value(out_result_value), .out_end_of_run(out_end_of_run)
  );

  always #5 clk = ~clk;

  task automatic predict_lcs(input logic f, input logic [VW-1:0] v, input logic l,
                             output int length);
    int i, j, total, emitted;
    lcs_result_t r;
    length = -1;
    if (f == lcs_pkg::FUNC_FIRST) begin
      if (len_a < MAX_LEN) begin
        seq_a[len_a] = v;
        len_a++;
      end else begin
        dropped++;
      end
      return;
    end
    if (len_b < MAX_LEN) begin
      seq_b[len_b] = v;
      len_b++;
    end else begin
      dropped++;
    end
    if (!l) return;
    for (i = len_a; i >= 0; i--) begin
      for (j = len_b; j >= 0; j--) begin
        if (i == len_a || j == len_b) suffix_lcs[i][j] = 0;
        else if (seq_a[i] == seq_b[j]) suffix_lcs[i][j] = (suffix_lcs[i+1][j+1] + 1) & 63;
        else if (suffix_lcs[i+1][j] >= suffix_lcs[i][j+1]) suffix_lcs[i][j] = suffix_lcs[i+1][j];
        else suffix_lcs[i][j] = suffix_lcs[i][j+1];
      end
    end
    total = suffix_lcs[0][0];
    length = total;
    r.kind = lcs_pkg::KIND_LENGTH;
    r.value = VW'(total);
    r.eor = (total == 0);
    pending_results = {pending_results, r};
    emitted = 0;
    i = 0;
    j = 0;
    while (i < len_a && j < len_b && emitted < total) begin
      if (seq_a[i] == seq_b[j]) begin
        emitted++;
        r.kind = lcs_pkg::KIND_ELEMENT;
        r.value = seq_a[i];
        r.eor = (emitted == total);
        pending_results = {pending_results, r};
        i++;
        j++;
      end else if (suffix_lcs[i+1][j] >= suffix_lcs[i][j+1]) begin
        i++;
      end else begin
        j++;
      end
    end
    len_a = 0;
    len_b = 0;
    runs_done++;
  endtask

  task automatic send_elem(input logic f, input logic [VW-1:0] v, input logic l,
                           output int length);
    in_func <= f;
    in_value <= v;
    in_last <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    elems_sent++;
    predict_lcs(f, v, l, length);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_pair(input int n, input int m, input bit wide, input bit mix);
    int ia, ib, len;
    logic [VW-1:0] v;
    ia = 0;
    ib = 0;
    while (ia < n || ib < m) begin
      v = wide ? VW'($urandom) : VW'($urandom_range(0, 3));
      if (ia < n && (!mix || ib == m - 1 || $urandom_range(0, 1) == 1)) begin
        send_elem(lcs_pkg::FUNC_FIRST, v,
                  (ia == n - 1) ? 1'($urandom) : 1'($urandom_range(0, 7) == 0), len);
        ia++;
      end else begin
        send_elem(FUNC_SECOND, v, ib == m - 1, len);
        ib++;
      end
    end
  endtask

  function automatic int pick_len(input int lo);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(30, 36);
    if (r == 1) return lo;
    return $urandom_range(lo, 8);
  endfunction

  always @(posedge clk) begin
    lcs_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected transaction: kind %0b value %h end %0b",
                   out_kind, out_result_value, out_end_of_run);
      end else begin
        e = pending_results.pop_front();
        if (out_kind !== e.kind || out_result_value !== e.value || out_end_of_run !== e.eor) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected kind %0b value %h end %0b, got %0b %h %0b",
                     e.kind, e.value, e.eor, out_kind, out_result_value, out_end_of_run);
        end
      end
    end
  end

  initial begin
    int hold_left, stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  initial begin
    elem_row_t directed[] = '{
      '{FUNC_SECOND,          32'd5,        1'b1, 1'b1, 0},
      '{lcs_pkg::FUNC_FIRST,  32'hFFFFFFFF, 1'b1, 1'b0, 0},
      '{FUNC_SECOND,          32'hFFFFFFFF, 1'b1, 1'b1, 1},
      '{lcs_pkg::FUNC_FIRST,  32'h00000000, 1'b0, 1'b0, 0},
      '{lcs_pkg::FUNC_FIRST,  32'h00000001, 1'b0, 1'b0, 0},
      '{lcs_pkg::FUNC_FIRST,  32'h00000002, 1'b1, 1'b0, 0},
      '{FUNC_SECOND,          32'h00000007, 1'b0, 1'b0, 0},
      '{FUNC_SECOND,          32'h00000008, 1'b1, 1'b1, 0},
      '{lcs_pkg::FUNC_FIRST,  32'd3,        1'b0, 1'b0, 0},
      '{FUNC_SECOND,          32'd1,        1'b0, 1'b0, 0},
      '{lcs_pkg::FUNC_FIRST,  32'd1,        1'b1, 1'b0, 0},
      '{FUNC_SECOND,          32'd3,        1'b1, 1'b0, 0},
      '{lcs_pkg::FUNC_FIRST,  32'h0000FFFF, 1'b0, 1'b0, 0},
      '{lcs_pkg::FUNC_FIRST,  32'hFFFF0000, 1'b0, 1'b0, 0},
      '{FUNC_SECOND,          32'hFFFF0000, 1'b0, 1'b0, 0},
      '{FUNC_SECOND,          32'h0000FFFF, 1'b1, 1'b1, 1}
    };
    int len, pairs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[k]) begin
      send_elem(directed[k].func, directed[k].value, directed[k].last, len);
      if (directed[k].has_len && len != directed[k].len) begin
        errors++;
        $display("Row %0d: predicted length %0d, table says %0d", k, len, directed[k].len);
      end
    end
    pairs = 0;
    while (elems_sent < 270) begin
      if (elems_sent > 220) calm = 1'b1;
      if (pairs == 3) hold_req = 1'b1;
      if (pairs == 6) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_pair(pick_len(0), pick_len(1), $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
      pairs++;
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d elements in %0d computations, %0d dropped for overflow.",
             elems_sent, runs_done, dropped);
    $display("Checked %0d result transactions, %0d errors.", results_seen, errors);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
